// File: design/relocate_move_top3_selector_assert.svh
// ----------------------------------------------------------------------------
// Relocate move top-3 selector assertion macros
// Shared property forms for the port-level checker of the selector.
// ----------------------------------------------------------------------------
`ifndef RELOCATE_MOVE_TOP3_SELECTOR_ASSERT_SVH
`define RELOCATE_MOVE_TOP3_SELECTOR_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define RMT3S_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("selector check failed: same-cycle property");

// Next-cycle implication, ignored while reset is high.
`define RMT3S_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("selector check failed: next-cycle property");

// Next-cycle implication that is also checked across reset.
`define RMT3S_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("selector check failed: reset property");

`endif

// File: design/rmt3s_pkg.sv
// ----------------------------------------------------------------------------
// Relocate move top-3 selector package
// Widths, constants and types shared by the cost and ranking stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rmt3s_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int RANKS         = 3;
  localparam int POS_W         = 10;
  localparam int COST_W        = 32;

  localparam logic [13:0]              PENALTY_WEIGHT = 14'd10000;
  localparam logic signed [COST_W-1:0] COST_UNFILLED  = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [POS_W-1:0]         position;
    logic                     last;
  } cost_item_t;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [POS_W-1:0]         position;
  } rank_entry_t;

  localparam rank_entry_t RANK_CLEAR = '{cost: COST_UNFILLED, position: '0};

endpackage

`default_nettype wire

// File: design/rmt3s_cost.sv
// ----------------------------------------------------------------------------
// Relocate move cost stage
// Registers one candidate and computes its move cost with load penalties.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt3s_cost import rmt3s_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       capacity,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       cost_from_edge_start,
  input  logic [15:0]       cost_to_edge_end,
  input  logic signed [17:0] removal_saving,
  input  logic [15:0]       target_route_load,
  input  logic [15:0]       origin_route_load,
  input  logic [15:0]       client_demand,
  input  logic              same_route,
  input  logic [POS_W-1:0]  position_index,
  input  logic              last_of_client,
  output logic              cost_valid,
  input  logic              cost_ready,
  output cost_item_t        cost_item
);

  typedef struct packed {
    logic [15:0]        from_start;
    logic [15:0]        to_end;
    logic signed [17:0] saving;
    logic [15:0]        target;
    logic [15:0]        origin;
    logic [15:0]        demand;
    logic               same;
    logic [POS_W-1:0]   position;
    logic               last;
  } raw_item_t;

  raw_item_t  cand;
  logic       cand_valid;
  logic       cand_move;
  cost_item_t cost_item_next;

  logic [16:0] tgt_sum;
  logic [16:0] tgt_excess;
  logic        tgt_over;
  logic [30:0] tgt_pen;
  logic [15:0] remaining;
  logic        org_over;
  logic [15:0] org_excess;
  logic [29:0] org_pen;
  logic [30:0] tgt_pen_kept;
  logic [31:0] cost_sum;

  assign cand_move = cand_valid && (!cost_valid || cost_ready);
  assign in_ready  = !cand_valid || cand_move;

  always_comb begin
    tgt_sum    = {1'b0, cand.target} + {1'b0, cand.demand};
    tgt_over   = tgt_sum > {1'b0, capacity};
    tgt_excess = tgt_sum - {1'b0, capacity};
    tgt_pen    = {14'b0, tgt_excess} * {17'b0, PENALTY_WEIGHT};
    // A route on which the client already sits carries no target overflow.
    tgt_pen_kept = (tgt_over && !cand.same) ? tgt_pen : '0;

    // The remaining origin load is negative when demand exceeds the load;
    // such a value never exceeds the capacity.
    remaining  = cand.origin - cand.demand;
    org_over   = (cand.origin >= cand.demand) && (remaining > capacity);
    org_excess = remaining - capacity;
    org_pen    = org_over ? ({14'b0, org_excess} * {16'b0, PENALTY_WEIGHT}) : '0;

    cost_sum = {16'b0, cand.from_start} + {16'b0, cand.to_end}
             - {{14{cand.saving[17]}}, cand.saving}
             + {1'b0, tgt_pen_kept} + {2'b0, org_pen};

    cost_item_next.cost     = cost_sum;
    cost_item_next.position = cand.position;
    cost_item_next.last     = cand.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
      cost_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        cand_valid <= in_valid;
      end
      if (!cost_valid || cost_ready) begin
        cost_valid <= cand_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cand.from_start <= cost_from_edge_start;
      cand.to_end     <= cost_to_edge_end;
      cand.saving     <= removal_saving;
      cand.target     <= target_route_load;
      cand.origin     <= origin_route_load;
      cand.demand     <= client_demand;
      cand.same       <= same_route;
      cand.position   <= position_index;
      cand.last       <= last_of_client;
    end
    if (cand_move) begin
      cost_item <= cost_item_next;
    end
  end

endmodule

`default_nettype wire

// File: design/rmt3s_rank.sv
// ----------------------------------------------------------------------------
// Relocate move ranking stage
// Keeps the three lowest costs of a client and emits them on its last item.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt3s_rank import rmt3s_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cost_valid,
  output logic                     cost_ready,
  input  cost_item_t               cost_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POS_W-1:0]         best_position,
  output logic signed [COST_W-1:0] best_cost,
  output logic [POS_W-1:0]         second_position,
  output logic signed [COST_W-1:0] second_cost,
  output logic [POS_W-1:0]         third_position,
  output logic signed [COST_W-1:0] third_cost
);

  rank_entry_t ranks [RANKS];
  rank_entry_t ranked [RANKS];
  rank_entry_t out_rank [RANKS];
  rank_entry_t fresh;
  logic        take;
  logic        in_range;

  // Only a last item needs the output register free.
  assign cost_ready = !cost_item.last || !out_valid || out_ready;
  assign take       = cost_valid && cost_ready;
  assign in_range   = 32'(cost_item.position) < MAX_POSITIONS;

  always_comb begin
    fresh.cost     = cost_item.cost;
    fresh.position = cost_item.position;
    for (int i = 0; i < RANKS; i++) begin
      ranked[i] = ranks[i];
    end
    // Strict compares so that an earlier item keeps its place on a tie.
    if (in_range) begin
      priority if (cost_item.cost < ranks[0].cost) begin
        ranked[2] = ranks[1];
        ranked[1] = ranks[0];
        ranked[0] = fresh;
      end else if (cost_item.cost < ranks[1].cost) begin
        ranked[2] = ranks[1];
        ranked[1] = fresh;
      end else if (cost_item.cost < ranks[2].cost) begin
        ranked[2] = fresh;
      end else begin
        // A cost at or above all three ranks leaves them as they are.
        ranked[2] = ranks[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < RANKS; i++) begin
        ranks[i] <= RANK_CLEAR;
      end
    end else begin
      if (take && cost_item.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (cost_item.last) begin
          for (int i = 0; i < RANKS; i++) begin
            ranks[i] <= RANK_CLEAR;
          end
        end else begin
          for (int i = 0; i < RANKS; i++) begin
            ranks[i] <= ranked[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cost_item.last) begin
      for (int i = 0; i < RANKS; i++) begin
        out_rank[i] <= ranked[i];
      end
    end
  end

  assign best_position   = out_rank[0].position;
  assign best_cost       = out_rank[0].cost;
  assign second_position = out_rank[1].position;
  assign second_cost     = out_rank[1].cost;
  assign third_position  = out_rank[2].position;
  assign third_cost      = out_rank[2].cost;

endmodule

`default_nettype wire

// File: design/relocate_move_top3_selector.sv
// ----------------------------------------------------------------------------
// Relocate move top-3 selector
// Scores relocate candidates and reports the three cheapest per client.
// ----------------------------------------------------------------------------
// The block takes one candidate per clock and presents a result after the client's
// last candidate is accepted: the candidate is registered, its cost is computed
// into a second register, and the ranking unit inserts it into the three kept
// ranks and loads the output register on a last item. The compare and insert
// loop of the ranking unit is combinational and sets the rate of one candidate
// per cycle; input is held back only while a last candidate waits on a result
// that has not been taken. The capacity register is written through the cfg
// channel, which is always ready, and is read by the cost stage.
// ----------------------------------------------------------------------------
`default_nettype none

module relocate_move_top3_selector import rmt3s_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [15:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              cost_from_edge_start,
  input  logic [15:0]              cost_to_edge_end,
  input  logic signed [17:0]       removal_saving,
  input  logic [15:0]              target_route_load,
  input  logic [15:0]              origin_route_load,
  input  logic [15:0]              client_demand,
  input  logic                     same_route,
  input  logic [POS_W-1:0]         position_index,
  input  logic                     last_of_client,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POS_W-1:0]         best_position,
  output logic signed [COST_W-1:0] best_cost,
  output logic [POS_W-1:0]         second_position,
  output logic signed [COST_W-1:0] second_cost,
  output logic [POS_W-1:0]         third_position,
  output logic signed [COST_W-1:0] third_cost
);

  logic [15:0] vehicle_capacity;
  logic        cost_valid;
  logic        cost_ready;
  cost_item_t  cost_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_capacity <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vehicle_capacity <= cfg_data;
    end
  end

  rmt3s_cost u_cost (
    .clk                  (clk),
    .rst                  (rst),
    .capacity             (vehicle_capacity),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .cost_from_edge_start (cost_from_edge_start),
    .cost_to_edge_end     (cost_to_edge_end),
    .removal_saving       (removal_saving),
    .target_route_load    (target_route_load),
    .origin_route_load    (origin_route_load),
    .client_demand        (client_demand),
    .same_route           (same_route),
    .position_index       (position_index),
    .last_of_client       (last_of_client),
    .cost_valid           (cost_valid),
    .cost_ready           (cost_ready),
    .cost_item            (cost_item)
  );

  rmt3s_rank u_rank (
    .clk             (clk),
    .rst             (rst),
    .cost_valid      (cost_valid),
    .cost_ready      (cost_ready),
    .cost_item       (cost_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .best_position   (best_position),
    .best_cost       (best_cost),
    .second_position (second_position),
    .second_cost     (second_cost),
    .third_position  (third_position),
    .third_cost      (third_cost)
  );

endmodule

`default_nettype wire

// File: design/rmt3s_checker.sv
// ----------------------------------------------------------------------------
// Relocate move top-3 selector checker
// Port-level properties of the selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "relocate_move_top3_selector_assert.svh"

module rmt3s_checker import rmt3s_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [POS_W-1:0]         best_position,
  input  logic signed [COST_W-1:0] best_cost,
  input  logic [POS_W-1:0]         second_position,
  input  logic signed [COST_W-1:0] second_cost,
  input  logic [POS_W-1:0]         third_position,
  input  logic signed [COST_W-1:0] third_cost
);

  // A result never appears in the cycle after reset.
  `RMT3S_ASSERT_RST(a_no_result_after_reset, rst, !out_valid)

  // A stalled result keeps its ranking.
  `RMT3S_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(best_cost) && $stable(second_cost) && $stable(third_cost) && $stable(best_position) && $stable(second_position) && $stable(third_position))

  // The ranks come out in order of cost.
  `RMT3S_ASSERT_NOW(a_ranks_sorted, out_valid, best_cost <= second_cost && second_cost <= third_cost)

  // No real cost reaches the unfilled mark, so an unfilled rank has position zero.
  `RMT3S_ASSERT_NOW(a_unfilled_position, out_valid && third_cost == COST_UNFILLED, third_position == '0)

endmodule

bind relocate_move_top3_selector rmt3s_checker u_rmt3s_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .best_position   (best_position),
  .best_cost       (best_cost),
  .second_position (second_position),
  .second_cost     (second_cost),
  .third_position  (third_position),
  .third_cost      (third_cost)
);

`default_nettype wire

// File: test/relocate_move_top3_selector_test.sv
// ----------------------------------------------------------------------------
// Relocate move top-3 selector testbench
// Streams relocate candidates through the selector under several vehicle
// capacities and handshake patterns. A ranking board recomputes each move cost
// and the three cheapest positions per client, and compares every reported
// ranking with the oldest one it expects.
// ----------------------------------------------------------------------------
`default_nettype none

module relocate_move_top3_selector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmt3s_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [15:0]        from_start;
    logic [15:0]        to_end;
    logic signed [17:0] saving;
    logic [15:0]        target_load;
    logic [15:0]        origin_load;
    logic [15:0]        demand;
    logic               same_route;
    logic [POS_W-1:0]   position;
    logic               last;
  } candidate_t;

  typedef rank_entry_t [RANKS-1:0] ranking_t;

  class move_ranking_board;
    longint   capacity;
    ranking_t ranks;
    ranking_t expected_rankings[$];
    int       mismatches;

    function new();
      capacity   = 0;
      mismatches = 0;
      clear_ranks();
    endfunction

    function void clear_ranks();
      for (int i = 0; i < RANKS; i++) ranks[i] = RANK_CLEAR;
    endfunction

    // Strict less-than keeps the earlier candidate on a tie.
    function void place_cost(logic signed [COST_W-1:0] cost, logic [POS_W-1:0] pos);
      if (cost < $signed(ranks[0].cost)) begin
        ranks[2] = ranks[1];
        ranks[1] = ranks[0];
        ranks[0] = '{cost: cost, position: pos};
      end else if (cost < $signed(ranks[1].cost)) begin
        ranks[2] = ranks[1];
        ranks[1] = '{cost: cost, position: pos};
      end else if (cost < $signed(ranks[2].cost)) begin
        ranks[2] = '{cost: cost, position: pos};
      end
    endfunction

    function void note_candidate(candidate_t c);
      longint load_in;
      longint remaining;
      longint penalty;
      longint cost;
      load_in   = longint'(c.target_load) + longint'(c.demand);
      remaining = longint'(c.origin_load) - longint'(c.demand);
      penalty   = 0;
      if (load_in > capacity) penalty = longint'(PENALTY_WEIGHT) * (load_in - capacity);
      if (c.same_route) penalty = 0;
      if (remaining > capacity) penalty += longint'(PENALTY_WEIGHT) * (remaining - capacity);
      cost = longint'(c.from_start) + longint'(c.to_end) - longint'(c.saving) + penalty;
      if (int'(c.position) < MAX_POSITIONS) place_cost(cost[COST_W-1:0], c.position);
      if (c.last) begin
        expected_rankings.push_back(ranks);
        clear_ranks();
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_ranking(ranking_t got);
      ranking_t want;
      string    label;
      if (expected_rankings.size() == 0) begin
        report_mismatch($sformatf("ranking with no request waiting, best %0d at %0d",
                                  $signed(got[0].cost), got[0].position));
      end else begin
        want = expected_rankings.pop_front();
        for (int i = 0; i < RANKS; i++) begin
          label = (i == 0) ? "best" : (i == 1) ? "second" : "third";
          if (got[i].position !== want[i].position)
            report_mismatch($sformatf("%s_position got %0d expected %0d",
                                      label, got[i].position, want[i].position));
          if (got[i].cost !== want[i].cost)
            report_mismatch($sformatf("%s_cost got %0d expected %0d", label,
                                      $signed(got[i].cost), $signed(want[i].cost)));
        end
      end
    endtask

    function int pending();
      return expected_rankings.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [15:0]              cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [15:0]              cost_from_edge_start = '0;
  logic [15:0]              cost_to_edge_end = '0;
  logic signed [17:0]       removal_saving = '0;
  logic [15:0]              target_route_load = '0;
  logic [15:0]              origin_route_load = '0;
  logic [15:0]              client_demand = '0;
  logic                     same_route = 1'b0;
  logic [POS_W-1:0]         position_index = '0;
  logic                     last_of_client = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [POS_W-1:0]         best_position;
  logic signed [COST_W-1:0] best_cost;
  logic [POS_W-1:0]         second_position;
  logic signed [COST_W-1:0] second_cost;
  logic [POS_W-1:0]         third_position;
  logic signed [COST_W-1:0] third_cost;

  int send_idle_pct = 22;
  int recv_idle_pct = 87;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int stall_cycles  = 0;

  move_ranking_board board;
  candidate_t        seen;
  ranking_t          got;

  relocate_move_top3_selector u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .cost_from_edge_start (cost_from_edge_start),
    .cost_to_edge_end     (cost_to_edge_end),
    .removal_saving       (removal_saving),
    .target_route_load    (target_route_load),
    .origin_route_load    (origin_route_load),
    .client_demand        (client_demand),
    .same_route           (same_route),
    .position_index       (position_index),
    .last_of_client       (last_of_client),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .best_position        (best_position),
    .best_cost            (best_cost),
    .second_position      (second_position),
    .second_cost          (second_cost),
    .third_position       (third_position),
    .third_cost           (third_cost)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The first time the receiver is told not to idle, it holds off for a long
  // stretch so that a finished ranking backs up and stalls new requests.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (recv_idle_pct == 0 && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.capacity = longint'(cfg_data);
      if (in_valid && in_ready) begin
        seen.from_start  = cost_from_edge_start;
        seen.to_end      = cost_to_edge_end;
        seen.saving      = removal_saving;
        seen.target_load = target_route_load;
        seen.origin_load = origin_route_load;
        seen.demand      = client_demand;
        seen.same_route  = same_route;
        seen.position    = position_index;
        seen.last        = last_of_client;
        board.note_candidate(seen);
      end
      if (out_valid && out_ready) begin
        got[0] = '{cost: best_cost, position: best_position};
        got[1] = '{cost: second_cost, position: second_position};
        got[2] = '{cost: third_cost, position: third_position};
        board.check_ranking(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic candidate_t make_candidate(int from, int to, int saving, int target,
                                                int origin, int demand, bit same,
                                                int pos, bit last);
    candidate_t c;
    c.from_start  = 16'(from);
    c.to_end      = 16'(to);
    c.saving      = 18'(saving);
    c.target_load = 16'(target);
    c.origin_load = 16'(origin);
    c.demand      = 16'(demand);
    c.same_route  = same;
    c.position    = POS_W'(pos);
    c.last        = last;
    return c;
  endfunction

  function automatic logic [15:0] load_near(int center);
    int v;
    v = center + int'($urandom_range(0, 800)) - 400;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Loads cluster around the capacity so that both penalty terms switch
  // on and off; a repeated candidate under a new position makes a tie.
  function automatic candidate_t random_candidate(int cap, candidate_t prev);
    candidate_t c;
    if ($urandom_range(0, 7) == 0) begin
      c = prev;
    end else begin
      c.from_start = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 2000));
      c.to_end     = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 2000));
      c.saving     = 18'($urandom_range(0, 262143));
      c.demand     = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 400));
      c.target_load = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                                  : load_near(cap - int'(c.demand));
      c.origin_load = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                                  : load_near(cap + int'(c.demand));
      c.same_route = 1'($urandom_range(0, 1));
    end
    c.position = POS_W'($urandom_range(0, MAX_POSITIONS - 1));
    c.last     = 1'b0;
    return c;
  endfunction

  task send_candidate(candidate_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    cost_from_edge_start <= c.from_start;
    cost_to_edge_end     <= c.to_end;
    removal_saving       <= c.saving;
    target_route_load    <= c.target_load;
    origin_route_load    <= c.origin_load;
    client_demand        <= c.demand;
    same_route           <= c.same_route;
    position_index       <= c.position;
    last_of_client       <= c.last;
    do @(posedge clk); while (!in_ready);
  endtask

  task write_capacity(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Let every ranking come out and the cost pipeline empty before the
  // capacity changes.
  task drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task run_phase(logic [15:0] cap, int send_pct, int recv_pct, int count);
    candidate_t c;
    candidate_t prev;
    int         sent;
    int         len;
    drain();
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    write_capacity(cap);
    prev = '0;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        c      = random_candidate(int'(cap), prev);
        c.last = (k == len - 1);
        send_candidate(c);
        prev = c;
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With zero capacity any nonzero load overflows, which drives the penalty
    // terms to their extremes.
    write_capacity(16'h0000);
    send_candidate(make_candidate(0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_candidate(make_candidate(65535, 65535, -131072, 65535, 65535, 65535, 0, 1023, 0));
    send_candidate(make_candidate(100, 100, 0, 65535, 65535, 0, 1, 5, 0));
    send_candidate(make_candidate(0, 0, 131071, 0, 0, 65535, 1, 512, 0));
    send_candidate(make_candidate(0, 0, 131071, 0, 0, 65535, 1, 7, 0));
    send_candidate(make_candidate(1, 2, 3, 4, 5, 6, 0, 300, 1));
    send_candidate(make_candidate(500, 0, 0, 0, 0, 0, 0, 10, 0));
    send_candidate(make_candidate(300, 0, 0, 0, 0, 0, 0, 11, 0));
    send_candidate(make_candidate(400, 0, 0, 0, 0, 0, 0, 12, 0));
    send_candidate(make_candidate(300, 0, 0, 0, 0, 0, 0, 13, 0));
    send_candidate(make_candidate(100, 0, 0, 0, 0, 0, 0, 14, 1));
    send_candidate(make_candidate(40000, 25535, -131072, 65535, 0, 0, 0, 1000, 0));
    send_candidate(make_candidate(0, 65535, -1, 0, 65535, 0, 0, 2, 1));
    send_candidate(make_candidate(65535, 65535, -131072, 65535, 65535, 0, 0, 1023, 1));
    send_candidate(make_candidate(65535, 65535, -131072, 65535, 65535, 0, 1, 682, 1));
    send_candidate(make_candidate(21845, 43690, 87381, 43690, 21845, 43690, 0, 341, 1));

    run_phase(16'hFFFF, 22, 87, 65);
    run_phase(16'($urandom_range(1, 65534)), 22, 87, 65);
    run_phase(16'h0000, 87, 22, 65);
    run_phase(16'($urandom_range(1, 255)), 87, 22, 65);
    run_phase(16'($urandom_range(1, 65534)), 0, 0, 65);
    run_phase(16'hFFFF, 0, 0, 65);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
